FILE: rtl/core/sws_pkg.sv
package sws_pkg;

  typedef enum logic [1:0] {
    FUNC_SEND = 2'd0,
    FUNC_PKT  = 2'd1,
    FUNC_TICK = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KIND_TX      = 3'd0,
    KIND_RETX    = 3'd1,
    KIND_FULL    = 3'd2,
    KIND_ACK     = 3'd3,
    KIND_IGNORED = 3'd4,
    KIND_NOTHING = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    REG_MAX_INFLIGHT = 3'd0,
    REG_RETX_THRESH  = 3'd1,
    REG_TICK_MS      = 3'd2,
    REG_PROTOCOL_ID  = 3'd3,
    REG_ACK_TYPE     = 3'd4
  } reg_e;

  // Classified command passed from front to back.
  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_ONE  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    kind_e       kind;
    logic [10:0] seg_len;
    logic [15:0] ack_number;
    logic [15:0] adv_window;
  } cmd_t;

  localparam logic [15:0] PEER_WINDOW_RESET = 16'd9216;

endpackage

FILE: rtl/core/sliding_window_sender_core.sv
// Sender side of a sliding-window transport for one connection.
// Input channel (in_valid/in_stall): one item per send, received control
// packet or timer tick, selected by func_i. Output channel
// (out_valid/out_stall): result items; last_o marks the final one of an item.
// An item leaves the two-entry queue when the back engine is idle and its
// result register is free. A send, ignored packet or unused code loads its
// one result on that edge; such items flow at one per cycle while out_stall
// is low. An ACK drops one front entry a cycle, then reports.
// A tick scans the window one entry a cycle while the result register is
// free, then closes the scan; each due segment is presented when the next
// due one is found, and the closing result releases the last one held.
// A stalled result holds; the back engine waits, the queue fills, then
// in_stall rises. Reset clears counters, the clock and the window; the ring
// itself holds no reset value and is only read after it is written.
// Configuration: cfg_valid/cfg_ready, always ready. It is to be written
// only while idle; the block itself does not enforce this.
module sliding_window_sender_core #(
  parameter int WINDOW_DEPTH = 16,
  parameter int MAX_CHUNK    = 1024,
  parameter int HEADER_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func_i,
  input  logic [10:0] chunk_len_i,
  input  logic [7:0]  pkt_protocol_i,
  input  logic [7:0]  pkt_type_i,
  input  logic [15:0] ack_number_i,
  input  logic [15:0] adv_window_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind_o,
  output logic [15:0] seq_out_o,
  output logic [10:0] seg_len_o,
  output logic [4:0]  in_flight_o,
  output logic        last_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import sws_pkg::*;

  logic [4:0]  max_inflight_q;
  logic [15:0] retx_q;
  logic [9:0]  tick_q;
  logic [7:0]  proto_q, ackt_q;
  logic        qv, pop;
  cmd_t        qd;

  assign cfg_ready = 1'b1;

  // Hold register values; take a write whenever the handshake completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_inflight_q <= 5'd16; retx_q <= 16'd30; tick_q <= 10'd10;
      proto_q <= '0; ackt_q <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_e'(cfg_index_i))
        REG_MAX_INFLIGHT: max_inflight_q <= cfg_data_i[4:0];
        REG_RETX_THRESH:  retx_q <= cfg_data_i;
        REG_TICK_MS:      tick_q <= cfg_data_i[9:0];
        REG_PROTOCOL_ID:  proto_q <= cfg_data_i[7:0];
        REG_ACK_TYPE:     ackt_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  sws_front #(.MAX_CHUNK(MAX_CHUNK), .HEADER_BYTES(HEADER_BYTES)) u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .func_i, .chunk_len_i,
    .pkt_protocol_i, .pkt_type_i, .ack_number_i, .adv_window_i,
    .protocol_id_i(proto_q), .ack_type_code_i(ackt_q),
    .q_valid_o(qv), .q_data_o(qd), .q_pop_i(pop)
  );

  sws_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_data_i(qd), .q_pop_o(pop),
    .max_inflight_i(max_inflight_q), .retx_threshold_ms_i(retx_q),
    .tick_ms_i(tick_q), .out_valid, .out_stall, .kind_o, .seq_out_o,
    .seg_len_o, .in_flight_o, .last_o
  );

endmodule

FILE: rtl/core/sws_front.sv
module sws_front #(
  parameter int MAX_CHUNK    = 1024,
  parameter int HEADER_BYTES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    func_i,
  input  logic [10:0]   chunk_len_i,
  input  logic [7:0]    pkt_protocol_i,
  input  logic [7:0]    pkt_type_i,
  input  logic [15:0]   ack_number_i,
  input  logic [15:0]   adv_window_i,
  input  logic [7:0]    protocol_id_i,
  input  logic [7:0]    ack_type_code_i,
  output logic          q_valid_o,
  output sws_pkg::cmd_t q_data_o,
  input  logic          q_pop_i
);
  import sws_pkg::*;

  localparam int QD = 2;

  cmd_t        mem_q [QD];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  cmd_t        cmd;
  logic [10:0] clip;
  logic        push;

  always_comb begin
    clip = (chunk_len_i > 11'(MAX_CHUNK)) ? 11'(MAX_CHUNK) : chunk_len_i;
    cmd.ack_number  = ack_number_i;
    cmd.adv_window  = adv_window_i;
    cmd.seg_len     = 11'(HEADER_BYTES) + clip;
    cmd.kind        = KIND_NOTHING;
    cmd.cmd         = CMD_ONE;
    case (func_e'(func_i))
      FUNC_SEND: if (chunk_len_i != 11'd0) cmd.cmd = CMD_SEND;
      FUNC_PKT: begin
        if (pkt_protocol_i == protocol_id_i && pkt_type_i == ack_type_code_i)
          cmd.cmd = CMD_ACK;
        else
          cmd.kind = KIND_IGNORED;
      end
      FUNC_TICK: cmd.cmd = CMD_TICK;
      default: cmd.cmd = CMD_ONE;
    endcase
  end

  assign in_stall  = (cnt_q == 2'(QD));
  assign push      = in_valid && !in_stall;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |-> q_valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'(QD))
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !q_pop_i) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("count missed push");

endmodule

FILE: rtl/core/sws_back.sv
module sws_back #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  sws_pkg::cmd_t q_data_i,
  output logic          q_pop_o,
  input  logic [4:0]    max_inflight_i,
  input  logic [15:0]   retx_threshold_ms_i,
  input  logic [9:0]    tick_ms_i,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    kind_o,
  output logic [15:0]   seq_out_o,
  output logic [10:0]   seg_len_o,
  output logic [4:0]    in_flight_o,
  output logic          last_o
);
  import sws_pkg::*;

  localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = IW + 1;

  typedef enum logic [1:0] { ST_IDLE, ST_ACK, ST_TICK } state_e;

  logic [15:0] seq_mem  [WINDOW_DEPTH];
  logic [10:0] len_mem  [WINDOW_DEPTH];
  logic [31:0] time_mem [WINDOW_DEPTH];

  state_e      state_q;
  logic [IW-1:0] head_q;
  logic [CW-1:0] count_q, idx_q;
  logic [15:0] next_seq_q, base_q, peer_win_q, ack_q;
  logic [31:0] now_q;
  logic        any_q;
  logic [15:0] pseq_q;
  logic [10:0] plen_q;

  logic          ov_q;
  logic [2:0]    kind_q;
  logic [15:0]   seq_q;
  logic [10:0]   len_q;
  logic [4:0]    fl_q;
  logic          last_q;

  logic          free;
  logic [CW-1:0] limit;
  logic [IW-1:0] slot, tail;
  logic [SW-1:0] tail_sum, slot_sum;
  logic          ent_due;
  logic [31:0]   age;

  assign free      = !ov_q || !out_stall;
  assign limit     = (max_inflight_i > 5'(WINDOW_DEPTH)) ? CW'(WINDOW_DEPTH)
                                                         : CW'(max_inflight_i);
  // Ring positions wrap by compare and subtract.
  assign tail_sum  = SW'(head_q) + SW'(count_q);
  assign slot_sum  = SW'(head_q) + SW'(idx_q);
  assign tail      = (tail_sum >= SW'(WINDOW_DEPTH)) ? IW'(tail_sum - SW'(WINDOW_DEPTH))
                                                     : IW'(tail_sum);
  assign slot      = (slot_sum >= SW'(WINDOW_DEPTH)) ? IW'(slot_sum - SW'(WINDOW_DEPTH))
                                                     : IW'(slot_sum);
  assign age       = now_q - time_mem[slot];
  assign ent_due   = age >= {16'd0, retx_threshold_ms_i};
  assign q_pop_o   = (state_q == ST_IDLE) && q_valid_i && free;

  assign out_valid   = ov_q;
  assign kind_o      = kind_q;
  assign seq_out_o   = seq_q;
  assign seg_len_o   = len_q;
  assign in_flight_o = fl_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_data_i.cmd == CMD_SEND && count_q < limit) begin
      seq_mem[tail]  <= next_seq_q;
      len_mem[tail]  <= q_data_i.seg_len;
      time_mem[tail] <= now_q;
    end
    if (state_q == ST_TICK && free && idx_q < count_q && ent_due)
      time_mem[slot] <= now_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; head_q <= '0; count_q <= '0; idx_q <= '0;
      next_seq_q <= '0; base_q <= '0; peer_win_q <= PEER_WINDOW_RESET;
      now_q <= '0; any_q <= 1'b0; ack_q <= '0; ov_q <= 1'b0;
      pseq_q <= '0; plen_q <= '0;
      kind_q <= '0; seq_q <= '0; len_q <= '0; fl_q <= '0; last_q <= 1'b0;
    end else begin
      if (ov_q && !out_stall) ov_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (q_pop_o) begin
          seq_q <= '0; len_q <= '0; last_q <= 1'b1; fl_q <= 5'(count_q);
          case (q_data_i.cmd)
            CMD_SEND: begin
              ov_q <= 1'b1;
              if (count_q < limit) begin
                kind_q <= KIND_TX; seq_q <= next_seq_q; len_q <= q_data_i.seg_len;
                count_q <= count_q + CW'(1); fl_q <= 5'(count_q + CW'(1));
                next_seq_q <= next_seq_q + 16'd1;
              end else kind_q <= KIND_FULL;
            end
            CMD_ACK: begin
              peer_win_q <= q_data_i.adv_window;
              ack_q <= q_data_i.ack_number;
              state_q <= ST_ACK;
            end
            CMD_TICK: begin
              now_q <= now_q + {22'd0, tick_ms_i};
              idx_q <= '0; any_q <= 1'b0;
              state_q <= ST_TICK;
            end
            default: begin ov_q <= 1'b1; kind_q <= q_data_i.kind; end
          endcase
        end
        ST_ACK: begin
          // Drop one front entry per cycle while it is below the ack.
          if (count_q != '0 && seq_mem[head_q] < ack_q) begin
            head_q  <= (head_q == IW'(WINDOW_DEPTH - 1)) ? '0 : head_q + IW'(1);
            count_q <= count_q - CW'(1);
          end else if (free) begin
            base_q <= ack_q;
            ov_q <= 1'b1; kind_q <= KIND_ACK; seq_q <= '0; len_q <= '0;
            fl_q <= 5'(count_q); last_q <= 1'b1; state_q <= ST_IDLE;
          end
        end
        ST_TICK: if (free) begin
          if (idx_q >= count_q) begin
            // End of scan: release the held retransmit, or a nothing result if none is held, as the last result.
            ov_q <= 1'b1; fl_q <= 5'(count_q); last_q <= 1'b1; state_q <= ST_IDLE;
            if (any_q) begin
              kind_q <= KIND_RETX; seq_q <= pseq_q; len_q <= plen_q;
            end else begin
              kind_q <= KIND_NOTHING; seq_q <= '0; len_q <= '0;
            end
          end else begin
            idx_q <= idx_q + CW'(1);
            if (ent_due) begin
              // Hold the segment due now; release the one held before it.
              if (any_q) begin
                ov_q <= 1'b1; kind_q <= KIND_RETX; seq_q <= pseq_q; len_q <= plen_q;
                fl_q <= 5'(count_q); last_q <= 1'b0;
              end
              any_q <= 1'b1; pseq_q <= seq_mem[slot]; plen_q <= len_mem[slot];
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  logic unused_base;
  assign unused_base = ^{base_q, peer_win_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(WINDOW_DEPTH))
    else $error("window overfull");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall) |=> ov_q && $stable(seq_q) && $stable(kind_q))
    else $error("result changed under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q == ST_IDLE)
    else $error("pop while busy");

endmodule
